// ----- design/hmcss_pkg.sv -----
// Shared types and constants of the hour and minute clock with seven-segment outputs.
`default_nettype none

package hmcss_pkg;

	localparam logic [15:0] TPM_RESET  = 16'd6000;
	localparam logic [5:0]  MINUTE_MAX = 6'd59;
	localparam logic [4:0]  HOUR_MAX   = 5'd23;

	typedef struct packed {
		logic tick;
		logic set_minute;
		logic set_hour;
		logic clear;
	} hmcss_item_t;

	typedef struct packed {
		logic [15:0] prescale;
		logic [5:0]  minute;
		logic [4:0]  hour;
	} hmcss_time_t;

	typedef struct packed {
		logic [7:0] minute_ones;
		logic [7:0] minute_tens;
		logic [7:0] hour_ones;
		logic [7:0] hour_tens;
	} hmcss_segs_t;

endpackage

`default_nettype wire

// ----- design/hmcss_time_update.sv -----
// Next-state logic of the prescaler, minute and hour counters for one item.
`default_nettype none

module hmcss_time_update
	import hmcss_pkg::*;
(
	input  hmcss_item_t item,
	input  hmcss_time_t cur,
	input  logic [15:0] ticks_per_minute,
	output hmcss_time_t nxt
);

	function automatic logic [5:0] inc_minute(input logic [5:0] m);
		return (m < MINUTE_MAX) ? m + 6'd1 : 6'd0;
	endfunction

	function automatic logic [4:0] inc_hour(input logic [4:0] h);
		return (h < HOUR_MAX) ? h + 5'd1 : 5'd0;
	endfunction

	logic [15:0] count_set;
	logic [5:0]  minute_set;
	logic [5:0]  minute_adv;
	logic [4:0]  hour_set;

	always_comb begin
		count_set  = item.clear ? 16'd0 : cur.prescale + 16'd1;
		minute_set = item.clear ? 6'd0 :
			(item.set_minute ? inc_minute(cur.minute) : cur.minute);
		hour_set   = item.clear ? 5'd0 :
			(item.set_hour ? inc_hour(cur.hour) : cur.hour);
		minute_adv = inc_minute(minute_set);

		nxt = cur;
		if (item.tick) begin
			if (count_set == ticks_per_minute) begin
				nxt.prescale = 16'd0;
				nxt.minute   = minute_adv;
				nxt.hour     = (minute_adv == 6'd0) ? inc_hour(hour_set) : hour_set;
			end else begin
				nxt.prescale = count_set;
				nxt.minute   = minute_set;
				nxt.hour     = hour_set;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/hmcss_seg_encode.sv -----
// Splits minutes and hours into decimal digits and encodes active-low segment patterns.
`default_nettype none

module hmcss_seg_encode
	import hmcss_pkg::*;
(
	input  logic [5:0]  minute,
	input  logic [4:0]  hour,
	output hmcss_segs_t segs
);

	function automatic logic [2:0] tens_of(input logic [5:0] v);
		if (v >= 6'd60)      return 3'd6;
		else if (v >= 6'd50) return 3'd5;
		else if (v >= 6'd40) return 3'd4;
		else if (v >= 6'd30) return 3'd3;
		else if (v >= 6'd20) return 3'd2;
		else if (v >= 6'd10) return 3'd1;
		else                 return 3'd0;
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [6:0] p;
		unique case (d)
			4'd1:    p = 7'h06;
			4'd2:    p = 7'h5B;
			4'd3:    p = 7'h4F;
			4'd4:    p = 7'h66;
			4'd5:    p = 7'h6D;
			4'd6:    p = 7'h7D;
			4'd7:    p = 7'h07;
			4'd8:    p = 7'h7F;
			4'd9:    p = 7'h6F;
			default: p = 7'h3F;
		endcase
		return ~{1'b0, p};
	endfunction

	logic [2:0] m_tens;
	logic [2:0] h_tens;
	logic [5:0] m_ones;
	logic [5:0] h_ones;

	always_comb begin
		m_tens = tens_of(minute);
		h_tens = tens_of({1'b0, hour});
		m_ones = minute - 6'({3'd0, m_tens} * 6'd10);
		h_ones = {1'b0, hour} - 6'({3'd0, h_tens} * 6'd10);

		segs.minute_ones = seg_of(m_ones[3:0]);
		segs.minute_tens = seg_of({1'b0, m_tens});
		segs.hour_ones   = seg_of(h_ones[3:0]);
		segs.hour_tens   = seg_of({1'b0, h_tens});
	end

endmodule

`default_nettype wire

// ----- design/hour_minute_clock_seven_segment.sv -----
// Top level of the 24-hour clock with seven-segment digit outputs.
//
// The block takes one beat per clock cycle. An accepted beat is held in an input
// register. When the result register is empty or its result is being taken, the counter update
// and segment encoding load the next result from that beat into the result register.
// The throughput of one beat per cycle holds as long as results are taken; a stalled
// result holds the input register, after which the block stalls its input. The
// ticks_per_minute register resets to 6000 and should be written only while idle.
`default_nettype none

module hour_minute_clock_seven_segment
	import hmcss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,

	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        tick,
	input  wire logic        set_minute_pressed,
	input  wire logic        set_hour_pressed,
	input  wire logic        clear_pressed,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [5:0]       minutes,
	output logic [4:0]       hours,
	output logic [7:0]       seg_minute_ones,
	output logic [7:0]       seg_minute_tens,
	output logic [7:0]       seg_hour_ones,
	output logic [7:0]       seg_hour_tens
);

	logic [15:0] tpm_q;
	hmcss_time_t time_q;
	hmcss_time_t time_next;
	hmcss_item_t item_s1;
	logic        valid_s1;
	logic        result_valid_q;
	hmcss_segs_t segs_next;
	hmcss_segs_t segs_q;
	logic [5:0]  minutes_q;
	logic [4:0]  hours_q;
	logic        advance;
	logic        accept;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	hmcss_time_update u_update (
		.item             (item_s1),
		.cur              (time_q),
		.ticks_per_minute (tpm_q),
		.nxt              (time_next)
	);

	hmcss_seg_encode u_seg (
		.minute (time_next.minute),
		.hour   (time_next.hour),
		.segs   (segs_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q          <= TPM_RESET;
			time_q         <= '0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tpm_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				time_q         <= time_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{tick: tick, set_minute: set_minute_pressed,
				set_hour: set_hour_pressed, clear: clear_pressed};
		end
		if (advance) begin
			minutes_q <= time_next.minute;
			hours_q   <= time_next.hour;
			segs_q    <= segs_next;
		end
	end

	assign result_valid    = result_valid_q;
	assign minutes         = minutes_q;
	assign hours           = hours_q;
	assign seg_minute_ones = segs_q.minute_ones;
	assign seg_minute_tens = segs_q.minute_tens;
	assign seg_hour_ones   = segs_q.hour_ones;
	assign seg_hour_tens   = segs_q.hour_tens;

endmodule

`default_nettype wire

// ----- tb/tb_hour_minute_clock_seven_segment.sv -----
// Self-checking testbench of the 24-hour clock with seven-segment digit outputs.
`timescale 1ns / 100ps
`default_nettype none

module tb_hour_minute_clock_seven_segment;
	import hmcss_pkg::*;

	typedef struct packed {
		logic [5:0]  minutes;
		logic [4:0]  hours;
		hmcss_segs_t segs;
	} clock_reading_t;

	localparam logic [6:0] DIGIT_SEGMENTS [0:9] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	localparam logic [15:0] PHASE_PERIODS [0:6] = '{
		16'd1, 16'd3, 16'd65535, 16'd0, 16'd2, 16'd60, 16'd1
	};
	localparam int PHASE_BEATS = 240;
	localparam int QUIET_LIMIT = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        tick = 1'b0;
	logic        set_minute_pressed = 1'b0;
	logic        set_hour_pressed = 1'b0;
	logic        clear_pressed = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [5:0]  minutes;
	logic [4:0]  hours;
	logic [7:0]  seg_minute_ones;
	logic [7:0]  seg_minute_tens;
	logic [7:0]  seg_hour_ones;
	logic [7:0]  seg_hour_tens;

	hmcss_item_t    pending_beats [$];
	clock_reading_t expected_readings [$];

	logic [15:0] minute_period = TPM_RESET;
	logic [15:0] prescale_q = '0;
	logic [5:0]  minute_q = '0;
	logic [4:0]  hour_q = '0;

	bit beat_taken = 1'b0;
	int in_hold = 0;
	int out_hold = 0;
	int in_odds = 0;
	int out_odds = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	hour_minute_clock_seven_segment DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.tick               (tick),
		.set_minute_pressed (set_minute_pressed),
		.set_hour_pressed   (set_hour_pressed),
		.clear_pressed      (clear_pressed),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.minutes            (minutes),
		.hours              (hours),
		.seg_minute_ones    (seg_minute_ones),
		.seg_minute_tens    (seg_minute_tens),
		.seg_hour_ones      (seg_hour_ones),
		.seg_hour_tens      (seg_hour_tens)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] digit_pattern(input int unsigned digit);
		return {1'b1, ~DIGIT_SEGMENTS[(digit < 10) ? digit : 0]};
	endfunction

	function automatic logic [5:0] next_minute(input logic [5:0] m);
		return (m < MINUTE_MAX) ? m + 6'd1 : 6'd0;
	endfunction

	function automatic logic [4:0] next_hour(input logic [4:0] h);
		return (h < HOUR_MAX) ? h + 5'd1 : 5'd0;
	endfunction

	function automatic clock_reading_t advance_clock(input hmcss_item_t beat);
		clock_reading_t reading;
		if (beat.tick) begin
			prescale_q = prescale_q + 16'd1;
			if (beat.set_minute)
				minute_q = next_minute(minute_q);
			if (beat.set_hour)
				hour_q = next_hour(hour_q);
			if (beat.clear) begin
				prescale_q = '0;
				minute_q = '0;
				hour_q = '0;
			end
			if (prescale_q == minute_period) begin
				prescale_q = '0;
				minute_q = next_minute(minute_q);
				if (minute_q == 6'd0)
					hour_q = next_hour(hour_q);
			end
		end
		reading.minutes = minute_q;
		reading.hours = hour_q;
		reading.segs.minute_ones = digit_pattern(minute_q % 10);
		reading.segs.minute_tens = digit_pattern(minute_q / 10);
		reading.segs.hour_ones = digit_pattern(hour_q % 10);
		reading.segs.hour_tens = digit_pattern(hour_q / 10);
		return reading;
	endfunction

	function automatic hmcss_item_t random_beat();
		hmcss_item_t beat;
		beat.tick = ($urandom_range(0, 99) < 85);
		beat.set_minute = ($urandom_range(0, 99) < 20);
		beat.set_hour = ($urandom_range(0, 99) < 10);
		beat.clear = ($urandom_range(0, 99) < 3);
		return beat;
	endfunction

	task automatic log_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// Waits until no beat is pending, in flight or awaiting its result.
	task automatic drain();
		while (pending_beats.size() != 0 || item_valid || expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [15:0] value);
		drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		clock_reading_t want;
		if (arst_n) begin
			beat_taken = item_valid && !item_stall;
			if (beat_taken)
				expected_readings.push_back(advance_clock({tick, set_minute_pressed,
					set_hour_pressed, clear_pressed}));
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					log_mismatch("result beat with no item waiting");
				end else begin
					want = expected_readings.pop_front();
					check_field("minutes", {2'b00, minutes}, {2'b00, want.minutes});
					check_field("hours", {3'b000, hours}, {3'b000, want.hours});
					check_field("seg_minute_ones", seg_minute_ones, want.segs.minute_ones);
					check_field("seg_minute_tens", seg_minute_tens, want.segs.minute_tens);
					check_field("seg_hour_ones", seg_hour_ones, want.segs.hour_ones);
					check_field("seg_hour_tens", seg_hour_tens, want.segs.hour_tens);
				end
			end
			if (cfg_valid && cfg_ready)
				minute_period = cfg_data;
			if (beat_taken || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	always @(negedge clk) begin
		hmcss_item_t beat;
		if (arst_n && (beat_taken || !item_valid)) begin
			if (pending_beats.size() == 0) begin
				item_valid <= 1'b0;
			end else if (in_hold != 0) begin
				in_hold--;
				item_valid <= 1'b0;
			end else if (in_odds != 0 && $urandom_range(1, in_odds) == 1) begin
				in_hold = $urandom_range(0, 13);
				item_valid <= 1'b0;
			end else begin
				beat = pending_beats.pop_front();
				item_valid <= 1'b1;
				tick <= beat.tick;
				set_minute_pressed <= beat.set_minute;
				set_hour_pressed <= beat.set_hour;
				clear_pressed <= beat.clear;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_hold != 0) begin
				out_hold--;
				result_stall <= 1'b1;
			end else if (out_odds != 0 && $urandom_range(1, out_odds) == 1) begin
				out_hold = $urandom_range(0, 13);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		do
			@(negedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_odds = 6;
		out_odds = 6;

		// Buttons with no tick, single and combined set presses, clear winning over sets.
		pending_beats.push_back('{tick: 0, set_minute: 1, set_hour: 1, clear: 1});
		pending_beats.push_back('{tick: 0, set_minute: 0, set_hour: 0, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 0, clear: 0});
		repeat (3) pending_beats.push_back('{tick: 1, set_minute: 1, set_hour: 0, clear: 0});
		repeat (3) pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 1, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 1, set_hour: 1, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 1, set_hour: 1, clear: 1});
		pending_beats.push_back('{tick: 0, set_minute: 0, set_hour: 0, clear: 1});
		pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 0, clear: 1});

		// A set press landing on the terminal count adds to the advance it causes.
		write_period(16'd2);
		pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 0, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 1, set_hour: 0, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 0, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 1, clear: 0});
		pending_beats.push_back('{tick: 1, set_minute: 1, set_hour: 1, clear: 1});
		pending_beats.push_back('{tick: 1, set_minute: 0, set_hour: 0, clear: 0});

		for (int p = 0; p < 7; p++) begin
			write_period(PHASE_PERIODS[p]);
			if (p == 2 || p == 6) begin
				in_odds = 0;
				out_odds = 0;
			end else begin
				in_odds = $urandom_range(2, 12);
				out_odds = $urandom_range(2, 12);
			end
			for (int n = 0; n < PHASE_BEATS; n++)
				pending_beats.push_back(random_beat());
		end

		drain();
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
